>>> hdl/aan_dct8_pkg.sv
// ----------------------------------------------------------------------------
// aan_dct8_pkg
// Types, widths and fixed-point constants shared by the 8-point forward DCT.
// ----------------------------------------------------------------------------
package aan_dct8_pkg;

   localparam int SampleW = 16;
   localparam int AW      = 17;   // first butterfly
   localparam int EW      = 18;   // second butterfly
   localparam int SW      = 19;   // third butterfly sums
   localparam int RW      = 35;   // Q14 coefficients before scaling
   localparam int ScaleW  = 16;   // Q14 scale factor, signed
   localparam int ProdW   = RW + ScaleW;
   localparam int FracC   = 14;
   localparam int ShiftW  = 24;   // Q28 down to Q4
   localparam int YW      = ProdW - ShiftW;
   localparam int CoefW   = 24;
   localparam int NumCoef = 8;

   // Register stages: six in the butterfly, two in the scaler.
   localparam int NumStages = 8;
   localparam int BflyStages = 6;

   localparam logic signed [ScaleW-1:0] K_C4    = 16'sd11585;
   localparam logic signed [ScaleW-1:0] K_C6    = 16'sd6270;
   localparam logic signed [ScaleW-1:0] K_C2MC6 = 16'sd8867;
   localparam logic signed [ScaleW-1:0] K_C2PC6 = 16'sd21407;
   localparam logic signed [ScaleW-1:0] K_ONE   = 16'sd16384;

   localparam logic signed [ProdW-1:0] RoundHalf = ProdW'(2**(ShiftW-1));
   localparam logic signed [YW-1:0]    CoefMax   = YW'(8388607);
   localparam logic signed [YW-1:0]    CoefMin   = -YW'(8388608);

   typedef logic [NumStages-1:0] stage_en_type;
   typedef logic signed [RW-1:0] r_type;

   typedef struct packed {
      logic signed [SampleW-1:0] sample_7;
      logic signed [SampleW-1:0] sample_6;
      logic signed [SampleW-1:0] sample_5;
      logic signed [SampleW-1:0] sample_4;
      logic signed [SampleW-1:0] sample_3;
      logic signed [SampleW-1:0] sample_2;
      logic signed [SampleW-1:0] sample_1;
      logic signed [SampleW-1:0] sample_0;
   } req_word_type;

   typedef struct packed {
      logic signed [CoefW-1:0] coef_7;
      logic signed [CoefW-1:0] coef_6;
      logic signed [CoefW-1:0] coef_5;
      logic signed [CoefW-1:0] coef_4;
      logic signed [CoefW-1:0] coef_3;
      logic signed [CoefW-1:0] coef_2;
      logic signed [CoefW-1:0] coef_1;
      logic signed [CoefW-1:0] coef_0;
   } rsp_word_type;

   // Q14 normalisation factors, 0.25/cos(k*pi/16), with cos(4*pi/16) for DC.
   function automatic logic signed [ScaleW-1:0] norm_q14(input logic [2:0] k);
      logic signed [ScaleW-1:0] f;
      case (k)
         3'd0:    f = 16'sd5793;
         3'd1:    f = 16'sd4176;
         3'd2:    f = 16'sd4433;
         3'd3:    f = 16'sd4926;
         3'd4:    f = 16'sd5793;
         3'd5:    f = 16'sd7373;
         3'd6:    f = 16'sd10703;
         3'd7:    f = 16'sd20995;
         default: f = K_ONE;
      endcase
      return f;
   endfunction

endpackage

>>> hdl/aan_dct8_pipe_ctl.sv
// ----------------------------------------------------------------------------
// aan_dct8_pipe_ctl
// Valid bits and per-stage load enables; bubbles close up under a stall.
// ----------------------------------------------------------------------------
module aan_dct8_pipe_ctl (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic                       rsp_stall,
   output aan_dct8_pkg::stage_en_type en,
   output logic                       req_stall,
   output logic                       rsp_valid
);

   localparam int N = aan_dct8_pkg::NumStages;

   logic [N-1:0] valid_ff;
   logic [N-1:0] valid_in;

   // A stage may load when it is empty or when the stage after it loads too.
   always_comb begin
      en[N-1] = !valid_ff[N-1] || !rsp_stall;
      for (int i = N - 2; i >= 0; i--) begin
         en[i] = !valid_ff[i] || en[i+1];
      end
   end

   always_comb begin
      for (int i = 0; i < N; i++) begin
         if (en[i]) begin
            valid_in[i] = (i == 0) ? req_valid : valid_ff[(i == 0) ? 0 : i - 1];
         end else begin
            valid_in[i] = valid_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_stall = !en[0];
   assign rsp_valid = valid_ff[N-1];

endmodule

>>> hdl/aan_dct8_butterfly.sv
// ----------------------------------------------------------------------------
// aan_dct8_butterfly
// Six-stage butterfly flow giving the eight unscaled Q14 coefficients.
// ----------------------------------------------------------------------------
module aan_dct8_butterfly (
   input  logic                        clock,
   input  logic [aan_dct8_pkg::BflyStages-1:0] en,
   input  aan_dct8_pkg::req_word_type  req_data,
   output aan_dct8_pkg::r_type         r_out [aan_dct8_pkg::NumCoef]
);

   localparam int AW    = aan_dct8_pkg::AW;
   localparam int EW    = aan_dct8_pkg::EW;
   localparam int SW    = aan_dct8_pkg::SW;
   localparam int RW    = aan_dct8_pkg::RW;
   localparam int FracC = aan_dct8_pkg::FracC;

   // Stage 1: first butterfly.
   logic signed [AW-1:0] a_ff [8];
   logic signed [AW-1:0] a_in [8];

   always_comb begin
      a_in[0] = AW'(req_data.sample_0) + AW'(req_data.sample_7);
      a_in[1] = AW'(req_data.sample_1) + AW'(req_data.sample_6);
      a_in[2] = AW'(req_data.sample_2) + AW'(req_data.sample_5);
      a_in[3] = AW'(req_data.sample_3) + AW'(req_data.sample_4);
      a_in[4] = AW'(req_data.sample_3) - AW'(req_data.sample_4);
      a_in[5] = AW'(req_data.sample_2) - AW'(req_data.sample_5);
      a_in[6] = AW'(req_data.sample_1) - AW'(req_data.sample_6);
      a_in[7] = AW'(req_data.sample_0) - AW'(req_data.sample_7);
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         a_ff <= a_in;
      end
   end

   // Stage 2: even butterfly and the odd partial sums.
   logic signed [EW-1:0] e0_ff, e1_ff, e2_ff, e3_ff, p_ff, q_ff, m_ff;
   logic signed [AW-1:0] a7b_ff;

   always_ff @(posedge clock) begin
      if (en[1]) begin
         e0_ff  <= EW'(a_ff[0]) + EW'(a_ff[3]);
         e1_ff  <= EW'(a_ff[1]) + EW'(a_ff[2]);
         e2_ff  <= EW'(a_ff[1]) - EW'(a_ff[2]);
         e3_ff  <= EW'(a_ff[0]) - EW'(a_ff[3]);
         p_ff   <= EW'(a_ff[4]) + EW'(a_ff[5]);
         q_ff   <= EW'(a_ff[6]) + EW'(a_ff[7]);
         m_ff   <= EW'(a_ff[5]) + EW'(a_ff[6]);
         a7b_ff <= a_ff[7];
      end
   end

   // Stage 3: last sums ahead of the multipliers.
   logic signed [SW-1:0] se_ff, de_ff, t_ff, pq_ff;
   logic signed [EW-1:0] e3c_ff, pc_ff, qc_ff, mc_ff;
   logic signed [AW-1:0] a7c_ff;

   always_ff @(posedge clock) begin
      if (en[2]) begin
         se_ff  <= SW'(e0_ff) + SW'(e1_ff);
         de_ff  <= SW'(e0_ff) - SW'(e1_ff);
         t_ff   <= SW'(e2_ff) + SW'(e3_ff);
         pq_ff  <= SW'(p_ff) + SW'(q_ff);
         e3c_ff <= e3_ff;
         pc_ff  <= p_ff;
         qc_ff  <= q_ff;
         mc_ff  <= m_ff;
         a7c_ff <= a7b_ff;
      end
   end

   // Stage 4: the five constant multiplies, everything brought to Q14.
   logic signed [RW-1:0] rot_ff, common_ff, qm_ff, pm_ff, mid_ff;
   logic signed [RW-1:0] a7q_ff, e3q_ff, r0d_ff, r4d_ff;

   always_ff @(posedge clock) begin
      if (en[3]) begin
         rot_ff    <= RW'(t_ff) * RW'(aan_dct8_pkg::K_C4);
         common_ff <= RW'(pq_ff) * RW'(aan_dct8_pkg::K_C6);
         qm_ff     <= RW'(qc_ff) * RW'(aan_dct8_pkg::K_C2MC6);
         pm_ff     <= RW'(pc_ff) * RW'(aan_dct8_pkg::K_C2PC6);
         mid_ff    <= RW'(mc_ff) * RW'(aan_dct8_pkg::K_C4);
         a7q_ff    <= RW'(a7c_ff) <<< FracC;
         e3q_ff    <= RW'(e3c_ff) <<< FracC;
         r0d_ff    <= RW'(se_ff) <<< FracC;
         r4d_ff    <= RW'(de_ff) <<< FracC;
      end
   end

   // Stage 5: rotation outputs and odd-part intermediates.
   logic signed [RW-1:0] u_ff, v_ff, lo_ff, hi_ff, r2e_ff, r6e_ff, r0e_ff, r4e_ff;

   always_ff @(posedge clock) begin
      if (en[4]) begin
         u_ff   <= common_ff + qm_ff;
         v_ff   <= common_ff - pm_ff;
         lo_ff  <= a7q_ff - mid_ff;
         hi_ff  <= a7q_ff + mid_ff;
         r2e_ff <= rot_ff + e3q_ff;
         r6e_ff <= e3q_ff - rot_ff;
         r0e_ff <= r0d_ff;
         r4e_ff <= r4d_ff;
      end
   end

   // Stage 6: final odd butterfly.
   logic signed [RW-1:0] r_ff [8];

   always_ff @(posedge clock) begin
      if (en[5]) begin
         r_ff[0] <= r0e_ff;
         r_ff[1] <= u_ff + hi_ff;
         r_ff[2] <= r2e_ff;
         r_ff[3] <= v_ff + lo_ff;
         r_ff[4] <= r4e_ff;
         r_ff[5] <= lo_ff - v_ff;
         r_ff[6] <= r6e_ff;
         r_ff[7] <= hi_ff - u_ff;
      end
   end

   assign r_out = r_ff;

endmodule

>>> hdl/aan_dct8_scale.sv
// ----------------------------------------------------------------------------
// aan_dct8_scale
// Optional normalisation, rounding to Q4 and saturation to 24 bits.
// ----------------------------------------------------------------------------
module aan_dct8_scale (
   input  logic                       clock,
   input  logic [1:0]                 en,
   input  logic                       apply_scaling,
   input  aan_dct8_pkg::r_type        r_in [aan_dct8_pkg::NumCoef],
   output aan_dct8_pkg::rsp_word_type rsp_data
);

   localparam int ProdW  = aan_dct8_pkg::ProdW;
   localparam int ScaleW = aan_dct8_pkg::ScaleW;
   localparam int YW     = aan_dct8_pkg::YW;
   localparam int CoefW  = aan_dct8_pkg::CoefW;
   localparam int N      = aan_dct8_pkg::NumCoef;

   // Without scaling the factor is one in Q14, so both modes share the
   // same Q28 rounding step.
   logic signed [ScaleW-1:0] factor [N];
   logic signed [ProdW-1:0]  prod_ff [N];

   always_comb begin
      for (int i = 0; i < N; i++) begin
         factor[i] = apply_scaling ? aan_dct8_pkg::norm_q14(3'(i)) : aan_dct8_pkg::K_ONE;
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         for (int i = 0; i < N; i++) begin
            prod_ff[i] <= ProdW'(r_in[i]) * ProdW'(factor[i]);
         end
      end
   end

   logic signed [ProdW-1:0] rounded [N];
   logic signed [YW-1:0]    y [N];
   logic signed [CoefW-1:0] sat [N];

   always_comb begin
      for (int i = 0; i < N; i++) begin
         rounded[i] = prod_ff[i] + aan_dct8_pkg::RoundHalf;
         y[i]       = rounded[i][ProdW-1:aan_dct8_pkg::ShiftW];
         if (y[i] > aan_dct8_pkg::CoefMax) begin
            sat[i] = y[i] > aan_dct8_pkg::CoefMax ? aan_dct8_pkg::CoefMax[CoefW-1:0] : '0;
         end else if (y[i] < aan_dct8_pkg::CoefMin) begin
            sat[i] = aan_dct8_pkg::CoefMin[CoefW-1:0];
         end else begin
            sat[i] = y[i][CoefW-1:0];
         end
      end
   end

   aan_dct8_pkg::rsp_word_type rsp_ff;

   always_ff @(posedge clock) begin
      if (en[1]) begin
         rsp_ff.coef_0 <= sat[0];
         rsp_ff.coef_1 <= sat[1];
         rsp_ff.coef_2 <= sat[2];
         rsp_ff.coef_3 <= sat[3];
         rsp_ff.coef_4 <= sat[4];
         rsp_ff.coef_5 <= sat[5];
         rsp_ff.coef_6 <= sat[6];
         rsp_ff.coef_7 <= sat[7];
      end
   end

   assign rsp_data = rsp_ff;

endmodule

>>> hdl/aan_forward_dct8_core.sv
// Eight-point forward DCT after the Arai-Agui-Nakajima flow. One word of
// eight signed 16-bit samples can be accepted every cycle, and its eight
// coefficients (Q4, rounded half up, saturated to 24 bits) leave through the
// register stages: six of butterflies and constant multiplies,
// one for the normalising multiply and one output register. Throughput is
// one word per cycle; a stall on the result side holds only the full stages,
// so empty stages keep taking words. The apply_scaling bit (reset 1) selects
// the 0.25/cos(k*pi/16) normalisation and should be written while idle.
// ----------------------------------------------------------------------------
// aan_forward_dct8_core
// Top level: configuration register, pipeline control and datapath.
// ----------------------------------------------------------------------------
module aan_forward_dct8_core (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  aan_dct8_pkg::req_word_type req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output aan_dct8_pkg::rsp_word_type rsp_data,
   input  logic                       csr_wr_en,
   input  logic                       csr_wr_data
);

   localparam int BS = aan_dct8_pkg::BflyStages;
   localparam int NS = aan_dct8_pkg::NumStages;

   logic apply_scaling_ff;
   logic apply_scaling_in;

   assign apply_scaling_in = csr_wr_en ? csr_wr_data : apply_scaling_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         apply_scaling_ff <= 1'b1;
      end else begin
         apply_scaling_ff <= apply_scaling_in;
      end
   end

   aan_dct8_pkg::stage_en_type en;
   aan_dct8_pkg::r_type        r_coef [aan_dct8_pkg::NumCoef];

   aan_dct8_pipe_ctl u_ctl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .rsp_stall (rsp_stall),
      .en        (en),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid)
   );

   aan_dct8_butterfly u_bfly (
      .clock    (clock),
      .en       (en[BS-1:0]),
      .req_data (req_data),
      .r_out    (r_coef)
   );

   aan_dct8_scale u_scale (
      .clock         (clock),
      .en            (en[NS-1:BS]),
      .apply_scaling (apply_scaling_ff),
      .r_in          (r_coef),
      .rsp_data      (rsp_data)
   );

endmodule
